FILE: design/rtd_pkg.sv
`timescale 1ns / 1ps
package rtd_pkg;

  localparam int unsigned AdcW     = 16;
  localparam int unsigned OhmW     = 16;
  localparam int unsigned CoefW    = 48;
  localparam int unsigned ResW     = 24;
  localparam int unsigned TempW    = 19;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned OutDataW = 48;

  // resistance is code * ref / 2^7 in q.8
  localparam int unsigned CodeW   = AdcW - 1;
  localparam int unsigned ProdW   = CodeW + OhmW;
  localparam int unsigned ResShift = 7;

  // ratio r = R / R0 in q.32
  localparam int unsigned FracQ  = 32;
  localparam int unsigned QuotW  = ResW + FracQ;
  localparam int unsigned RadW   = 104;
  localparam int unsigned SqrtW  = RadW / 2;
  localparam int unsigned NmW    = SqrtW + 9;
  localparam int unsigned NumW   = NmW + 9;
  localparam int unsigned QBits  = TempW;

  localparam int unsigned FifoDepthDef = 4;

  localparam logic [OhmW-1:0]  RefOhmsReset = OhmW'(430);
  localparam logic [OhmW-1:0]  NomOhmsReset = OhmW'(100);
  localparam logic [CoefW-1:0] CoeffAReset  = CoefW'(64'd1100088651478);
  localparam logic [CoefW-1:0] CoeffA2Reset = CoefW'(64'd4299476481);
  localparam logic [CoefW-1:0] Coeff4BReset = CoefW'(-64'sd650207196);
  localparam logic [CoefW-1:0] Coeff2BReset = CoefW'(-64'sd325103598);

  localparam logic [TempW-1:0] TempMax = {1'b0, {(TempW-1){1'b1}}};
  localparam logic [TempW-1:0] TempMin = {1'b1, {(TempW-1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    RegRefOhms  = 3'd0,
    RegNomOhms  = 3'd1,
    RegCoeffA   = 3'd2,
    RegCoeffA2  = 3'd3,
    RegCoeff4B  = 3'd4,
    RegCoeff2B  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [OhmW-1:0]  ref_ohms;
    logic [OhmW-1:0]  nominal_ohms;
    logic [CoefW-1:0] coeff_a;
    logic [CoefW-1:0] coeff_a_squared;
    logic [CoefW-1:0] coeff_four_b;
    logic [CoefW-1:0] coeff_two_b;
  } cfg_t;

  typedef struct packed {
    logic [ResW-1:0] res;
  } item_t;

  // magnitude of a two's complement coefficient
  function automatic logic [CoefW-1:0] mag_coef(input logic [CoefW-1:0] v);
    return v[CoefW-1] ? (~v + CoefW'(1)) : v;
  endfunction

endpackage

FILE: design/rtd_front.sv
`timescale 1ns / 1ps
module rtd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rtd_pkg::AdcW-1:0]      in_data_i,
  input  logic [rtd_pkg::OhmW-1:0]      ref_ohms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rtd_pkg::item_t                out_item_o
);

  logic                         valid_q;
  rtd_pkg::item_t               item_q;
  logic [rtd_pkg::ProdW-1:0]    prod;
  logic                         take;

  // fault bit dropped, code scaled by the reference resistor
  assign prod = rtd_pkg::ProdW'(in_data_i[rtd_pkg::AdcW-1:1]) * rtd_pkg::ProdW'(ref_ohms_i);
  assign in_ready_o = ~valid_q | out_ready_i;
  assign take = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.res <= prod[rtd_pkg::ResShift +: rtd_pkg::ResW];
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

FILE: design/rtd_fifo.sv
`timescale 1ns / 1ps
module rtd_fifo #(
  parameter int unsigned Depth = rtd_pkg::FifoDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rtd_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rtd_pkg::item_t out_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rtd_pkg::item_t    mem [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign in_ready_o  = count_q != CntW'(Depth);
  assign out_valid_o = count_q != '0;
  assign push = in_valid_i & in_ready_o;
  assign pop  = out_valid_o & out_ready_i;
  assign out_item_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

FILE: design/rtd_back.sv
`timescale 1ns / 1ps
module rtd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rtd_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rtd_pkg::item_t              in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rtd_pkg::ResW-1:0]    out_res_o,
  output logic [rtd_pkg::TempW-1:0]   out_temp_o,
  output logic                        out_err_o
);

  localparam int unsigned OhmW  = rtd_pkg::OhmW;
  localparam int unsigned CoefW = rtd_pkg::CoefW;
  localparam int unsigned ResW  = rtd_pkg::ResW;
  localparam int unsigned TempW = rtd_pkg::TempW;
  localparam int unsigned FracQ = rtd_pkg::FracQ;
  localparam int unsigned QuotW = rtd_pkg::QuotW;
  localparam int unsigned RadW  = rtd_pkg::RadW;
  localparam int unsigned SqrtW = rtd_pkg::SqrtW;
  localparam int unsigned NmW   = rtd_pkg::NmW;
  localparam int unsigned NumW  = rtd_pkg::NumW;
  localparam int unsigned QBits = rtd_pkg::QBits;
  localparam int unsigned LoW   = QuotW / 2;
  localparam int unsigned HiW   = QuotW - LoW;
  localparam int unsigned CLoW  = CoefW / 2;
  localparam int unsigned CHiW  = CoefW - CLoW;
  localparam int unsigned PpW   = CHiW + HiW;
  localparam int unsigned SumW  = PpW + LoW;
  localparam int unsigned RadSW = RadW + 2;
  localparam int unsigned TW    = RadW + 1;
  localparam logic [QuotW-1:0] OneQ = QuotW'(1) << FracQ;

  logic                 adv;
  logic [OhmW-1:0]      nom;
  logic [CoefW-1:0]     m2b, m4b, ma;

  assign adv = ~out_valid_o | out_ready_i;
  assign in_ready_o = adv;
  assign nom = (cfg_i.nominal_ohms == '0) ? OhmW'(1) : cfg_i.nominal_ohms;
  assign m2b = rtd_pkg::mag_coef(cfg_i.coeff_two_b);
  assign m4b = rtd_pkg::mag_coef(cfg_i.coeff_four_b);
  assign ma  = rtd_pkg::mag_coef(cfg_i.coeff_a);

  // ratio divider: one quotient bit per stage
  logic             a_v_q   [QuotW];
  logic [OhmW-1:0]  a_rem_q [QuotW];
  logic [QuotW-1:0] a_q_q   [QuotW];
  logic [ResW-1:0]  a_res_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_ratio
    localparam int BitPos = QuotW - 1 - k;
    logic             pv, dbit, ge;
    logic [OhmW-1:0]  prem;
    logic [QuotW-1:0] pq;
    logic [ResW-1:0]  pres;
    logic [OhmW:0]    trial;
    if (k == 0) begin : g_first
      assign pv   = in_valid_i;
      assign prem = '0;
      assign pq   = '0;
      assign pres = in_item_i.res;
    end else begin : g_next
      assign pv   = a_v_q[k-1];
      assign prem = a_rem_q[k-1];
      assign pq   = a_q_q[k-1];
      assign pres = a_res_q[k-1];
    end
    if (BitPos >= FracQ) begin : g_res_bit
      assign dbit = pres[BitPos-FracQ];
    end else begin : g_zero_bit
      assign dbit = 1'b0;
    end
    assign trial = {prem, dbit};
    assign ge = trial >= {1'b0, nom};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q[k] <= 1'b0;
      end else if (adv) begin
        a_v_q[k] <= pv;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        a_rem_q[k] <= ge ? OhmW'(trial - {1'b0, nom}) : trial[OhmW-1:0];
        a_q_q[k]   <= {pq[QuotW-2:0], ge};
        a_res_q[k] <= pres;
      end
    end
  end

  // radicand: |r - 1| times |4B| in four partial products, then A^2 - 4B(1 - r)
  logic             b1_v_q, b2_v_q, b3_v_q, b4_v_q, b5_v_q;
  logic [QuotW-1:0] b1_mx_q;
  logic             b1_nx_q;
  logic [PpW-1:0]   b2_pp_q [4];
  logic             b2_neg_q, b3_neg_q, b4_neg_q;
  logic [SumW-1:0]  b3_s0_q, b3_s1_q;
  logic [RadW-1:0]  b4_prod_q;
  logic [RadW-1:0]  b5_rad_q;
  logic             b5_err_q;
  logic [ResW-1:0]  b1_res_q, b2_res_q, b3_res_q, b4_res_q, b5_res_q;
  logic [QuotW-1:0] ratio;
  logic             nx;
  logic [RadSW-1:0] a2s, sprod, rad;

  assign ratio = a_q_q[QuotW-1];
  assign nx    = ratio > OneQ;
  assign a2s   = {{(RadSW-CoefW-FracQ){cfg_i.coeff_a_squared[CoefW-1]}},
                  cfg_i.coeff_a_squared, {FracQ{1'b0}}};
  assign sprod = b4_neg_q ? (~{2'b00, b4_prod_q} + RadSW'(1)) : {2'b00, b4_prod_q};
  assign rad   = a2s - sprod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
      b4_v_q <= 1'b0;
      b5_v_q <= 1'b0;
    end else if (adv) begin
      b1_v_q <= a_v_q[QuotW-1];
      b2_v_q <= b1_v_q;
      b3_v_q <= b2_v_q;
      b4_v_q <= b3_v_q;
      b5_v_q <= b4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_mx_q    <= nx ? ratio - OneQ : OneQ - ratio;
      b1_nx_q    <= nx;
      b1_res_q   <= a_res_q[QuotW-1];
      b2_pp_q[0] <= PpW'(m4b[CLoW-1:0]) * PpW'(b1_mx_q[LoW-1:0]);
      b2_pp_q[1] <= PpW'(m4b[CLoW-1:0]) * PpW'(b1_mx_q[QuotW-1:LoW]);
      b2_pp_q[2] <= PpW'(m4b[CoefW-1:CLoW]) * PpW'(b1_mx_q[LoW-1:0]);
      b2_pp_q[3] <= PpW'(m4b[CoefW-1:CLoW]) * PpW'(b1_mx_q[QuotW-1:LoW]);
      b2_neg_q   <= cfg_i.coeff_four_b[CoefW-1] ^ b1_nx_q;
      b2_res_q   <= b1_res_q;
      b3_s0_q    <= {b2_pp_q[1], {LoW{1'b0}}} + SumW'(b2_pp_q[0]);
      b3_s1_q    <= {b2_pp_q[3], {LoW{1'b0}}} + SumW'(b2_pp_q[2]);
      b3_neg_q   <= b2_neg_q;
      b3_res_q   <= b2_res_q;
      b4_prod_q  <= RadW'({b3_s1_q, {CLoW{1'b0}}}) + RadW'(b3_s0_q);
      b4_neg_q   <= b3_neg_q;
      b4_res_q   <= b3_res_q;
      b5_rad_q   <= rad[RadW-1:0];
      b5_err_q   <= rad[RadSW-1] | (m2b == '0);
      b5_res_q   <= b4_res_q;
    end
  end

  // square root, one result bit per stage on the running remainder
  logic             c_v_q   [SqrtW];
  logic [RadW-1:0]  c_r_q   [SqrtW];
  logic [SqrtW-1:0] c_s_q   [SqrtW];
  logic             c_err_q [SqrtW];
  logic [ResW-1:0]  c_res_q [SqrtW];

  for (genvar k = 0; k < SqrtW; k++) begin : g_sqrt
    localparam int BitPos = SqrtW - 1 - k;
    logic             pv, perr, ge;
    logic [RadW-1:0]  pr;
    logic [SqrtW-1:0] ps;
    logic [ResW-1:0]  pres;
    logic [TW-1:0]    t;
    if (k == 0) begin : g_first
      assign pv   = b5_v_q;
      assign pr   = b5_rad_q;
      assign ps   = '0;
      assign perr = b5_err_q;
      assign pres = b5_res_q;
    end else begin : g_next
      assign pv   = c_v_q[k-1];
      assign pr   = c_r_q[k-1];
      assign ps   = c_s_q[k-1];
      assign perr = c_err_q[k-1];
      assign pres = c_res_q[k-1];
    end
    // (s + 2^b)^2 - s^2
    assign t  = (TW'(ps) << (BitPos + 1)) | (TW'(1) << (2 * BitPos));
    assign ge = {1'b0, pr} >= t;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_v_q[k] <= 1'b0;
      end else if (adv) begin
        c_v_q[k] <= pv;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_r_q[k]   <= ge ? pr - t[RadW-1:0] : pr;
        c_s_q[k]   <= ge ? (ps | (SqrtW'(1) << BitPos)) : ps;
        c_err_q[k] <= perr;
        c_res_q[k] <= pres;
      end
    end
  end

  // numerator sqrt - A, rounding offset, range check of the quotient
  logic             d1_v_q, d2_v_q, d3_v_q;
  logic [NmW-1:0]   d1_nm_q;
  logic [NumW-1:0]  d2_n_q;
  logic             d1_neg_q, d2_neg_q, d3_neg_q;
  logic             d1_err_q, d2_err_q, d3_err_q;
  logic [ResW-1:0]  d1_res_q, d2_res_q, d3_res_q;
  logic [CoefW-1:0] d3_rem_q;
  logic [QBits-1:0] d3_low_q;
  logic             d3_ovf_q;
  logic [NmW-1:0]   sv, ma_ext, nm;
  logic             nn;
  logic [NumW-QBits-1:0] num_hi;

  assign sv     = {1'b0, c_s_q[SqrtW-1], 8'b0};
  assign ma_ext = NmW'(ma);
  assign num_hi = d2_n_q[NumW-1:QBits];

  always_comb begin
    nn = 1'b0;
    if (cfg_i.coeff_a[CoefW-1]) begin
      nm = sv + ma_ext;
    end else if (sv >= ma_ext) begin
      nm = sv - ma_ext;
    end else begin
      nm = ma_ext - sv;
      nn = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_v_q <= 1'b0;
      d2_v_q <= 1'b0;
      d3_v_q <= 1'b0;
    end else if (adv) begin
      d1_v_q <= c_v_q[SqrtW-1];
      d2_v_q <= d1_v_q;
      d3_v_q <= d2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_nm_q  <= nm;
      d1_neg_q <= nn ^ cfg_i.coeff_two_b[CoefW-1];
      d1_err_q <= c_err_q[SqrtW-1];
      d1_res_q <= c_res_q[SqrtW-1];
      d2_n_q   <= {d1_nm_q, 8'b0} + NumW'(m2b >> 1);
      d2_neg_q <= d1_neg_q;
      d2_err_q <= d1_err_q;
      d2_res_q <= d1_res_q;
      d3_ovf_q <= num_hi >= (NumW-QBits)'(m2b);
      d3_rem_q <= num_hi[CoefW-1:0];
      d3_low_q <= d2_n_q[QBits-1:0];
      d3_neg_q <= d2_neg_q;
      d3_err_q <= d2_err_q;
      d3_res_q <= d2_res_q;
    end
  end

  // low quotient bits of the final division
  logic             e_v_q   [QBits];
  logic [CoefW-1:0] e_rem_q [QBits];
  logic [QBits-1:0] e_q_q   [QBits];
  logic [QBits-1:0] e_low_q [QBits];
  logic             e_ovf_q [QBits];
  logic             e_neg_q [QBits];
  logic             e_err_q [QBits];
  logic [ResW-1:0]  e_res_q [QBits];

  for (genvar k = 0; k < QBits; k++) begin : g_quot
    localparam int BitPos = QBits - 1 - k;
    logic             pv, povf, pneg, perr, ge;
    logic [CoefW-1:0] prem;
    logic [QBits-1:0] pq, plow;
    logic [ResW-1:0]  pres;
    logic [CoefW:0]   trial;
    if (k == 0) begin : g_first
      assign pv   = d3_v_q;
      assign prem = d3_rem_q;
      assign pq   = '0;
      assign plow = d3_low_q;
      assign povf = d3_ovf_q;
      assign pneg = d3_neg_q;
      assign perr = d3_err_q;
      assign pres = d3_res_q;
    end else begin : g_next
      assign pv   = e_v_q[k-1];
      assign prem = e_rem_q[k-1];
      assign pq   = e_q_q[k-1];
      assign plow = e_low_q[k-1];
      assign povf = e_ovf_q[k-1];
      assign pneg = e_neg_q[k-1];
      assign perr = e_err_q[k-1];
      assign pres = e_res_q[k-1];
    end
    assign trial = {prem, plow[BitPos]};
    assign ge = trial >= {1'b0, m2b};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        e_v_q[k] <= 1'b0;
      end else if (adv) begin
        e_v_q[k] <= pv;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        e_rem_q[k] <= ge ? CoefW'(trial - {1'b0, m2b}) : trial[CoefW-1:0];
        e_q_q[k]   <= {pq[QBits-2:0], ge};
        e_low_q[k] <= plow;
        e_ovf_q[k] <= povf;
        e_neg_q[k] <= pneg;
        e_err_q[k] <= perr;
        e_res_q[k] <= pres;
      end
    end
  end

  // saturation and output register
  logic             out_valid_q, out_err_q, err_d;
  logic [ResW-1:0]  out_res_q;
  logic [TempW-1:0] out_temp_q, temp_d;
  logic [QBits-1:0] qf;

  assign qf = e_q_q[QBits-1];

  always_comb begin
    err_d  = 1'b0;
    temp_d = rtd_pkg::TempMax;
    if (e_err_q[QBits-1]) begin
      err_d = 1'b1;
    end else if (e_neg_q[QBits-1]) begin
      if (e_ovf_q[QBits-1] || qf > QBits'(rtd_pkg::TempMin)) begin
        temp_d = rtd_pkg::TempMin;
        err_d  = 1'b1;
      end else begin
        temp_d = TempW'(~qf + QBits'(1));
      end
    end else if (e_ovf_q[QBits-1] || qf > QBits'(rtd_pkg::TempMax)) begin
      err_d = 1'b1;
    end else begin
      temp_d = TempW'(qf);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= e_v_q[QBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q  <= e_res_q[QBits-1];
      out_temp_q <= temp_d;
      out_err_q  <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_temp_o  = out_temp_q;
  assign out_err_o   = out_err_q;

endmodule

FILE: design/rtd_adc_to_temperature_unit.sv
`timescale 1ns / 1ps
// RTD converter word to resistance and temperature. Each 16-bit word (fault bit
// dropped) gives one result word: resistance in q.8 ohms and temperature in
// signed q.8 degrees, from the inverse quadratic Callendar-Van Dusen form.
// One word per clock is sustained while the output is not stalled; a result
// passes the front multiplier register, the queue, the bit-per-stage ratio
// divider, the split radicand multiplier, the digit-per-stage square root,
// the numerator stages, the final quotient stages and the output register.
// A negative radicand or a zero 2B gives the top temperature with
// domain_error set; out-of-range quotients saturate and set domain_error.
// Registers may be written only while no word is in flight.
module rtd_adc_to_temperature_unit #(
  parameter int unsigned FifoDepth = rtd_pkg::FifoDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rtd_pkg::AdcW-1:0]        s_axis_tdata,   // adc_word
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rtd_pkg::OutDataW-1:0]    m_axis_tdata,   // resistance, temperature
  output logic [0:0]                      m_axis_tuser,   // domain_error
  input  logic                            cfg_we_i,
  input  logic [rtd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [rtd_pkg::CfgDataW-1:0]    cfg_data_i
);

  rtd_pkg::cfg_t  cfg_q;
  logic           front_valid, fifo_in_ready;
  logic           fifo_out_valid, back_in_ready;
  rtd_pkg::item_t front_item, fifo_item;
  logic [rtd_pkg::ResW-1:0]  out_res;
  logic [rtd_pkg::TempW-1:0] out_temp;
  logic           out_err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_ohms        <= rtd_pkg::RefOhmsReset;
      cfg_q.nominal_ohms    <= rtd_pkg::NomOhmsReset;
      cfg_q.coeff_a         <= rtd_pkg::CoeffAReset;
      cfg_q.coeff_a_squared <= rtd_pkg::CoeffA2Reset;
      cfg_q.coeff_four_b    <= rtd_pkg::Coeff4BReset;
      cfg_q.coeff_two_b     <= rtd_pkg::Coeff2BReset;
    end else if (cfg_we_i) begin
      case (rtd_pkg::cfg_reg_e'(cfg_idx_i))
        rtd_pkg::RegRefOhms: cfg_q.ref_ohms        <= cfg_data_i[rtd_pkg::OhmW-1:0];
        rtd_pkg::RegNomOhms: cfg_q.nominal_ohms    <= cfg_data_i[rtd_pkg::OhmW-1:0];
        rtd_pkg::RegCoeffA:  cfg_q.coeff_a         <= cfg_data_i[rtd_pkg::CoefW-1:0];
        rtd_pkg::RegCoeffA2: cfg_q.coeff_a_squared <= cfg_data_i[rtd_pkg::CoefW-1:0];
        rtd_pkg::RegCoeff4B: cfg_q.coeff_four_b    <= cfg_data_i[rtd_pkg::CoefW-1:0];
        rtd_pkg::RegCoeff2B: cfg_q.coeff_two_b     <= cfg_data_i[rtd_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  rtd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .ref_ohms_i  (cfg_q.ref_ohms),
    .out_valid_o (front_valid),
    .out_ready_i (fifo_in_ready),
    .out_item_o  (front_item)
  );

  rtd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (fifo_in_ready),
    .in_item_i   (front_item),
    .out_valid_o (fifo_out_valid),
    .out_ready_i (back_in_ready),
    .out_item_o  (fifo_item)
  );

  rtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (fifo_out_valid),
    .in_ready_o  (back_in_ready),
    .in_item_i   (fifo_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res),
    .out_temp_o  (out_temp),
    .out_err_o   (out_err)
  );

  assign m_axis_tdata = {{(rtd_pkg::OutDataW - rtd_pkg::ResW - rtd_pkg::TempW){1'b0}},
                         out_temp, out_res};
  assign m_axis_tuser = out_err;

  // input stalls only when the front holds a word the queue cannot take
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (front_valid && !fifo_in_ready))
    else $error("input stalled without a full queue");

  // an accepted word is held in the front stage the next cycle
  a_front_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> front_valid)
    else $error("accepted word lost in front stage");

endmodule

FILE: tb/rtd_adc_to_temperature_unit_test.sv
`timescale 1ns / 1ps
module rtd_adc_to_temperature_unit_test;
  import rtd_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned        DrainCycles = 160;

  typedef struct packed {
    logic [ResW-1:0]  res;
    logic [TempW-1:0] temp;
    logic             err;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [AdcW-1:0] s_axis_tdata = '0;       // adc_word
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // resistance, temperature
  logic [0:0] m_axis_tuser;                 // domain_error
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  rtd_adc_to_temperature_unit u_top (.*);

  initial forever #1 clk_i = ~clk_i;

  // local copy of the register file
  logic [15:0] ref_ohms_q = 16'd430;
  logic [15:0] nom_ohms_q = 16'd100;
  logic [47:0] a_q  = CoeffAReset;
  logic [47:0] a2_q = CoeffA2Reset;
  logic [47:0] b4_q = Coeff4BReset;
  logic [47:0] b2_q = Coeff2BReset;

  reading_t pending_readings[$];
  bit       failed = 1'b0;
  int       burst_left = 0;

  function automatic logic [63:0] coef_mag(input logic [47:0] v, output bit neg);
    logic [47:0] m;
    m   = ~v + 48'd1;
    neg = v[47];
    return neg ? 64'(m) : 64'(v);
  endfunction

  function automatic reading_t convert_word(input logic [AdcW-1:0] w);
    reading_t r;
    logic [63:0] code, res, nom, ratio, mx, m4b, ma2, ma, m2b, s, t, sv, nm;
    logic [127:0] a2s, prod, rad, num, q;
    bit nx, n4b, na2, na, n2b, nn;
    code  = 64'(w[15:1]);
    res   = (code * 64'(ref_ohms_q)) >> 7;
    nom   = (nom_ohms_q == 0) ? 64'd1 : 64'(nom_ohms_q);
    ratio = (res << 32) / nom;
    nx    = ratio > 64'h1_0000_0000;
    mx    = nx ? ratio - 64'h1_0000_0000 : 64'h1_0000_0000 - ratio;
    m4b   = coef_mag(b4_q, n4b);
    ma2   = coef_mag(a2_q, na2);
    ma    = coef_mag(a_q, na);
    m2b   = coef_mag(b2_q, n2b);
    a2s   = 128'(ma2) << 32;
    if (na2) a2s = -a2s;
    prod  = 128'(m4b) * 128'(mx);
    if (n4b != nx) prod = -prod;
    rad   = a2s - prod;
    r.res  = res[ResW-1:0];
    r.temp = TempMax;
    r.err  = 1'b0;
    if (rad[127] || m2b == 0) begin
      r.err = 1'b1;
    end else begin
      s = 0;
      for (int b = 52; b >= 0; b--) begin
        t = s | (64'd1 << b);
        if (128'(t) * 128'(t) <= rad) s = t;
      end
      sv = s << 8;
      if (na) begin
        nm = sv + ma; nn = 1'b0;
      end else if (sv >= ma) begin
        nm = sv - ma; nn = 1'b0;
      end else begin
        nm = ma - sv; nn = 1'b1;
      end
      num = (128'(nm) << 8) + 128'(m2b >> 1);
      q   = num / 128'(m2b);
      if (nn != n2b) begin
        if (q > 128'd262144) begin
          q = 128'd262144; r.err = 1'b1;
        end
        r.temp = TempW'(-q);
      end else begin
        if (q > 128'd262143) begin
          q = 128'd262143; r.err = 1'b1;
        end
        r.temp = TempW'(q);
      end
    end
    return r;
  endfunction

  // receiver stall pattern: random stretches, each free-running or choppy
  int stall_mode_left = 0;
  bit choppy = 1'b0;
  always @(posedge clk_i) begin
    if (stall_mode_left == 0) begin
      stall_mode_left <= $urandom_range(10, 200);
      choppy <= $urandom_range(0, 2) != 0;
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    m_axis_tready <= choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    reading_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.res  = m_axis_tdata[ResW-1:0];
      got.temp = m_axis_tdata[ResW +: TempW];
      got.err  = m_axis_tuser[0];
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected word res=%h temp=%h err=%b", $time,
                 got.res, got.temp, got.err);
        failed = 1'b1;
      end else begin
        want = pending_readings.pop_front();
        if (got.res !== want.res) begin
          $display("%0t: resistance expected %h actual %h", $time, want.res, got.res);
          failed = 1'b1;
        end
        if (got.temp !== want.temp) begin
          $display("%0t: temperature expected %h actual %h", $time, want.temp, got.temp);
          failed = 1'b1;
        end
        if (got.err !== want.err) begin
          $display("%0t: domain_error expected %b actual %b", $time, want.err, got.err);
          failed = 1'b1;
        end
        if (m_axis_tdata[OutDataW-1:ResW+TempW] !== '0) begin
          $display("%0t: pad bits expected 0 actual %h", $time,
                   m_axis_tdata[OutDataW-1:ResW+TempW]);
          failed = 1'b1;
        end
      end
    end
  end

  // valid stays high through a burst, drops for a random gap between bursts
  task automatic send_word(input logic [AdcW-1:0] w);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(convert_word(w));
    burst_left--;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [47:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegRefOhms: ref_ohms_q = val[15:0];
      RegNomOhms: nom_ohms_q = val[15:0];
      RegCoeffA:  a_q  = val;
      RegCoeffA2: a2_q = val;
      RegCoeff4B: b4_q = val;
      RegCoeff2B: b2_q = val;
      default: ;
    endcase
  endtask

  task automatic load_defaults;
    write_reg(RegRefOhms, 48'(RefOhmsReset));
    write_reg(RegNomOhms, 48'(NomOhmsReset));
    write_reg(RegCoeffA,  CoeffAReset);
    write_reg(RegCoeffA2, CoeffA2Reset);
    write_reg(RegCoeff4B, Coeff4BReset);
    write_reg(RegCoeff2B, Coeff2BReset);
  endtask

  function automatic logic [47:0] rand48;
    return {16'($urandom), $urandom};
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      // half the words near the physical range of a pt100 divider
      if ($urandom_range(0, 1)) send_word(16'($urandom_range(12000, 24000)));
      else send_word(16'($urandom));
    end
  endtask

  task automatic test_directed_reset_config;
    logic [AdcW-1:0] words[12] = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000,
                                   16'h7FFF, 16'd15240, 16'd15241, 16'd15242,
                                   16'd11000, 16'd20000, 16'hAAAA};
    foreach (words[i]) send_word(words[i]);
    drain();
  endtask

  task automatic test_corner_registers;
    // zero reference resistor
    write_reg(RegRefOhms, 48'd0);
    send_word(16'hFFFF); send_word(16'h1234);
    drain();
    write_reg(RegRefOhms, 48'hFFFF_FFFF_FFFF);
    // zero nominal resistance acts as one ohm
    write_reg(RegNomOhms, 48'd0);
    send_word(16'hFFFF); send_word(16'h0002);
    drain();
    write_reg(RegNomOhms, 48'd65535);
    send_word(16'hFFFF); send_word(16'h0000);
    drain();
    load_defaults();
    // zero divisor
    write_reg(RegCoeff2B, 48'd0);
    send_word(16'd15240); send_word(16'd20000);
    drain();
    // negative radicand
    write_reg(RegCoeff2B, Coeff2BReset);
    write_reg(RegCoeffA2, 48'h8000_0000_0000);
    send_word(16'd15240); send_word(16'd30000);
    drain();
    // extreme coefficients, register writes to an unused index are dropped
    write_reg(RegCoeffA,  48'h7FFF_FFFF_FFFF);
    write_reg(RegCoeffA2, 48'h7FFF_FFFF_FFFF);
    write_reg(RegCoeff4B, 48'h8000_0000_0000);
    write_reg(RegCoeff2B, 48'd1);
    write_reg(RegUnused,  48'hFFFF_FFFF_FFFF);
    send_word(16'h0000); send_word(16'hFFFF); send_word(16'd15240);
    drain();
    write_reg(RegCoeffA, 48'h8000_0000_0000);
    write_reg(RegCoeff2B, 48'h7FFF_FFFF_FFFF);
    send_word(16'h0000); send_word(16'hFFFF);
    drain();
  endtask

  task automatic test_random_phases;
    for (int p = 0; p < 6; p++) begin
      load_defaults();
      case (p % 3)
        1: begin
          // small perturbation of a realistic sensor setup
          write_reg(RegRefOhms, 48'($urandom_range(300, 4300)));
          write_reg(RegNomOhms, 48'($urandom_range(80, 1000)));
        end
        2: begin
          write_reg(RegRefOhms, rand48());
          write_reg(RegNomOhms, rand48());
          write_reg(RegCoeffA,  rand48());
          write_reg(RegCoeffA2, rand48());
          write_reg(RegCoeff4B, rand48());
          write_reg(RegCoeff2B, ($urandom_range(0, 1)) ? rand48() : 48'($urandom));
        end
        default: ;
      endcase
      send_random(300);
      drain();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_reset_config();
    test_corner_registers();
    test_random_phases();
    if (!failed && pending_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
design/rtd_pkg.sv
design/rtd_front.sv
design/rtd_fifo.sv
design/rtd_back.sv
design/rtd_adc_to_temperature_unit.sv
tb/rtd_adc_to_temperature_unit_test.sv
